// File: sv/sco_pkg.sv
// ----------------------------------------------------------------------------
// sco_pkg
// Shared constants for the smoothed camera offset block: field widths,
// register indexes, eye height and sine polynomial coefficients.
// ----------------------------------------------------------------------------
package sco_pkg;

    localparam int POS_W   = 32;
    localparam int OFS_W   = 16;
    localparam int ANG_W   = 16;
    localparam int SMO_W   = 9;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_RIGHT    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_UP       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_FORWARD  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_TRIM        = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_TRIM      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING       = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THIRD_ONLY      = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FOLLOW_LOOK     = 4'd7;

    localparam logic [SMO_W-1:0] SMOOTH_FULL = 9'd256;

    // eye height, 1.62 blocks in Q24.8
    localparam logic signed [33:0] EYE_HEIGHT = 34'sd415;
    localparam logic signed [33:0] ONE_BLOCK  = 34'sd256;
    localparam logic [18:0]        ONE_BLOCK_SQ = 19'd65536;

    // angles and sine polynomial, Q1.14
    localparam logic [ANG_W-1:0] HALF_TURN    = 16'd32768;
    localparam logic [ANG_W-1:0] QUARTER_TURN = 16'd16384;
    localparam logic [14:0]      SIN_ONE      = 15'd16384;
    localparam logic [14:0]      SIN_C1       = 15'd25736;
    localparam logic [14:0]      SIN_C3       = 15'd10584;
    localparam logic [14:0]      SIN_C5       = 15'd1302;

    // serial multiplier: signed A by signed B, one bit of B per cycle
    localparam int MUL_AW = 34;
    localparam int MUL_BW = 18;
    localparam int MUL_PW = MUL_AW + MUL_BW;

endpackage

// File: sv/smoothed_camera_offset.sv
// ----------------------------------------------------------------------------
// smoothed_camera_offset
// Camera placement per frame: third-person detection, plain or look-rotated
// offset from the player, and exponential smoothing toward the last camera.
//
// Usage:
//   Input stream (s_axis): one transaction per frame. tuser[0] is
//   world_ready; tdata carries player x/y/z, pitch, yaw and the default
//   camera x/y/z. Output stream (m_axis): one transaction per input, tuser
//   holds apply and third_person, tdata the new camera x/y/z (Q24.8).
//   Configuration writes go over the cfg channel (index, data), always
//   ready, and are expected only while the block is idle.
//   All products run through one bit-serial multiplier that retires one
//   bit of its 18-bit operand per cycle, after a load step for each
//   product. A frame with world not ready uses no products; the longest
//   frame needs the distance squares, four sines, seven offset products
//   and three blend products. The block works on one frame at a time.
//   The next frame is accepted while the previous result still waits in
//   the output register; the block stalls only when a second result is
//   finished before the first is taken.
//   Reset (synchronous, active low) loads the register defaults (smoothing
//   256, all else 0) and drops the smoothing history.
// ----------------------------------------------------------------------------
module smoothed_camera_offset (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // s_axis
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // player_x, player_y, player_z, look_pitch, look_yaw,
    // camera_x, camera_y, camera_z (lowest bit up)
    input  logic [223:0]                  i_s_tdata,
    // world_ready
    input  logic [0:0]                    i_s_tuser,
    // m_axis
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // new_x, new_y, new_z (lowest bit up)
    output logic [95:0]                   o_m_tdata,
    // apply, third_person (lowest bit up)
    output logic [1:0]                    o_m_tuser,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sco_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sco_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_LOAD, S_MUL, S_DIST, S_SAT, S_SMOOTH, S_FIN, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_DX, OP_DY, OP_DZ,
        OP_SZ2, OP_ST1, OP_ST2, OP_SP,
        OP_FWX, OP_FWZ, OP_XR, OP_XF, OP_YF, OP_ZR, OP_ZF,
        OP_MX, OP_MY, OP_MZ
    } t_op;

    localparam int AW = sco_pkg::MUL_AW;
    localparam int BW = sco_pkg::MUL_BW;
    localparam int PW = sco_pkg::MUL_PW;
    localparam logic [4:0] LAST_BIT = 5'(BW - 1);

    t_state r_state;
    t_op    r_op;

    // configuration
    logic signed [15:0] r_ofs_right, r_ofs_up, r_ofs_fwd;
    logic [15:0]        r_yaw_trim, r_pitch_trim;
    logic [8:0]         r_smoothing;
    logic               r_third_only, r_follow;

    // latched frame
    logic signed [31:0] r_px, r_py, r_pz, r_cx, r_cy, r_cz;
    logic [15:0]        r_pitch_in, r_yaw_in;

    // history
    logic signed [31:0] r_last_x, r_last_y, r_last_z;
    logic               r_has_last;

    // working values
    logic               r_third;
    logic [17:0]        r_dsum;
    logic [1:0]         r_idx;
    logic [14:0]        r_z2, r_t;
    logic signed [15:0] r_sy, r_cyw, r_sp, r_cp, r_fwx, r_fwz;
    logic signed [33:0] r_tx, r_ty, r_tz;

    // multiplier
    logic signed [PW-1:0] r_ma, r_acc;
    logic [BW-1:0]        r_mb;
    logic [4:0]           r_cnt;

    // pending result and output register
    logic        r_res_apply, r_res_third;
    logic [31:0] r_res_x, r_res_y, r_res_z;
    logic        r_out_valid;
    logic [95:0] r_out_data;
    logic [1:0]  r_out_user;

    // ---- distance differences and range check
    logic signed [33:0] w_dx, w_dy, w_dz;
    logic               w_far_range;
    assign w_dx = 34'(r_cx) - 34'(r_px);
    assign w_dy = 34'(r_cy) - 34'(r_py) - sco_pkg::EYE_HEIGHT;
    assign w_dz = 34'(r_cz) - 34'(r_pz);
    assign w_far_range = (w_dx > sco_pkg::ONE_BLOCK) || (w_dx < -sco_pkg::ONE_BLOCK) ||
                         (w_dy > sco_pkg::ONE_BLOCK) || (w_dy < -sco_pkg::ONE_BLOCK) ||
                         (w_dz > sco_pkg::ONE_BLOCK) || (w_dz < -sco_pkg::ONE_BLOCK);

    // ---- angle selection and half-turn fold
    logic [15:0]        w_yaw, w_pitch, w_ang;
    logic signed [16:0] w_x0, w_xf;
    logic [14:0]        w_m;
    logic               w_neg;
    assign w_yaw   = sco_pkg::HALF_TURN + r_yaw_in + r_yaw_trim;
    assign w_pitch = 16'd0 - (r_pitch_in + r_pitch_trim);
    always_comb begin
        case (r_idx)
            2'd0:    w_ang = w_yaw;
            2'd1:    w_ang = w_yaw + sco_pkg::QUARTER_TURN;
            2'd2:    w_ang = w_pitch;
            default: w_ang = w_pitch + sco_pkg::QUARTER_TURN;
        endcase
    end
    assign w_x0 = signed'({w_ang[15], w_ang});
    always_comb begin
        if (w_x0 > 17'sd16384) begin
            w_xf = 17'sd32768 - w_x0;
        end else if (w_x0 < -17'sd16384) begin
            w_xf = -17'sd32768 - w_x0;
        end else begin
            w_xf = w_x0;
        end
    end
    assign w_neg = w_xf < 0;
    assign w_m   = w_neg ? 15'(-w_xf) : 15'(w_xf);

    // ---- smoothing weight, clamped to one
    logic [8:0] w_s;
    assign w_s = (r_smoothing > sco_pkg::SMOOTH_FULL) ? sco_pkg::SMOOTH_FULL : r_smoothing;

    // ---- operand select for the shared multiplier
    logic signed [AW-1:0] w_opa;
    logic signed [BW-1:0] w_opb;
    always_comb begin
        case (r_op)
            OP_DX:   begin w_opa = w_dx; w_opb = w_dx[BW-1:0]; end
            OP_DY:   begin w_opa = w_dy; w_opb = w_dy[BW-1:0]; end
            OP_DZ:   begin w_opa = w_dz; w_opb = w_dz[BW-1:0]; end
            OP_SZ2:  begin w_opa = AW'(w_m); w_opb = BW'(w_m); end
            OP_ST1:  begin w_opa = AW'(sco_pkg::SIN_C5); w_opb = BW'(r_z2); end
            OP_ST2:  begin w_opa = AW'(r_z2); w_opb = BW'(r_t); end
            OP_SP:   begin w_opa = AW'(w_m); w_opb = BW'(r_t); end
            OP_FWX:  begin w_opa = AW'(r_sy); w_opb = BW'(r_cp); end
            OP_FWZ:  begin w_opa = AW'(r_cyw); w_opb = BW'(r_cp); end
            OP_XR:   begin w_opa = AW'(r_ofs_right); w_opb = BW'(r_cyw); end
            OP_XF:   begin w_opa = AW'(r_ofs_fwd); w_opb = BW'(r_fwx); end
            OP_YF:   begin w_opa = AW'(r_ofs_fwd); w_opb = BW'(r_sp); end
            OP_ZR:   begin w_opa = AW'(r_ofs_right); w_opb = BW'(r_sy); end
            OP_ZF:   begin w_opa = AW'(r_ofs_fwd); w_opb = BW'(r_fwz); end
            OP_MX:   begin w_opa = r_tx - 34'(r_last_x); w_opb = BW'({1'b0, w_s}); end
            OP_MY:   begin w_opa = r_ty - 34'(r_last_y); w_opb = BW'({1'b0, w_s}); end
            OP_MZ:   begin w_opa = r_tz - 34'(r_last_z); w_opb = BW'({1'b0, w_s}); end
            default: begin w_opa = '0; w_opb = '0; end
        endcase
    end

    // ---- one multiplier bit: the top bit of B carries negative weight
    logic signed [PW-1:0] w_add, w_prod, w_r14, w_r8, w_sh14;
    logic [14:0]          w_pmag;
    logic signed [15:0]   w_sin;
    assign w_add  = r_mb[0] ? ((r_cnt == LAST_BIT) ? -r_ma : r_ma) : '0;
    assign w_prod = r_acc + w_add;
    assign w_sh14 = w_prod >>> 14;
    assign w_r14  = (w_prod + PW'(8192)) >>> 14;
    assign w_r8   = (w_prod + PW'(128)) >>> 8;
    assign w_pmag = (w_sh14 > PW'(sco_pkg::SIN_ONE)) ? sco_pkg::SIN_ONE : w_sh14[14:0];
    assign w_sin  = w_neg ? -16'(w_pmag) : 16'(w_pmag);

    // ---- saturation helper
    function automatic logic signed [33:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) begin
            sat32 = 34'sd2147483647;
        end else if (v < -34'sd2147483648) begin
            sat32 = -34'sd2147483648;
        end else begin
            sat32 = v;
        end
    endfunction

    // ---- sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_op         <= OP_DX;
            r_ofs_right  <= '0;
            r_ofs_up     <= '0;
            r_ofs_fwd    <= '0;
            r_yaw_trim   <= '0;
            r_pitch_trim <= '0;
            r_smoothing  <= sco_pkg::SMOOTH_FULL;
            r_third_only <= 1'b0;
            r_follow     <= 1'b0;
            r_last_x     <= '0;
            r_last_y     <= '0;
            r_last_z     <= '0;
            r_has_last   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
            r_idx        <= '0;
        end else begin
            // take configuration writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    sco_pkg::REG_OFFSET_RIGHT:   r_ofs_right  <= signed'(i_cfg_data);
                    sco_pkg::REG_OFFSET_UP:      r_ofs_up     <= signed'(i_cfg_data);
                    sco_pkg::REG_OFFSET_FORWARD: r_ofs_fwd    <= signed'(i_cfg_data);
                    sco_pkg::REG_YAW_TRIM:       r_yaw_trim   <= i_cfg_data;
                    sco_pkg::REG_PITCH_TRIM:     r_pitch_trim <= i_cfg_data;
                    sco_pkg::REG_SMOOTHING:      r_smoothing  <= i_cfg_data[8:0];
                    sco_pkg::REG_THIRD_ONLY:     r_third_only <= i_cfg_data[0];
                    sco_pkg::REG_FOLLOW_LOOK:    r_follow     <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // drop the output transaction once taken, unless a new one is loaded
            if (r_out_valid && i_m_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_px       <= signed'(i_s_tdata[31:0]);
                        r_py       <= signed'(i_s_tdata[63:32]);
                        r_pz       <= signed'(i_s_tdata[95:64]);
                        r_pitch_in <= i_s_tdata[111:96];
                        r_yaw_in   <= i_s_tdata[127:112];
                        r_cx       <= signed'(i_s_tdata[159:128]);
                        r_cy       <= signed'(i_s_tdata[191:160]);
                        r_cz       <= signed'(i_s_tdata[223:192]);
                        if (i_s_tuser[0]) begin
                            r_state <= S_CHK;
                        end else begin
                            r_has_last  <= 1'b0;
                            r_res_apply <= 1'b0;
                            r_res_third <= 1'b0;
                            r_res_x     <= '0;
                            r_res_y     <= '0;
                            r_res_z     <= '0;
                            r_state     <= S_DONE;
                        end
                    end
                end

                // any axis beyond one block settles it without squares
                S_CHK: begin
                    if (w_far_range) begin
                        r_third <= 1'b1;
                        r_state <= S_DIST;
                    end else begin
                        r_op    <= OP_DX;
                        r_state <= S_LOAD;
                    end
                end

                S_LOAD: begin
                    r_ma    <= PW'(w_opa);
                    r_mb    <= w_opb;
                    r_acc   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_MUL;
                end

                S_MUL: begin
                    r_acc <= w_prod;
                    r_ma  <= r_ma <<< 1;
                    r_mb  <= r_mb >> 1;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == LAST_BIT) begin
                        // the last product of each group leaves the multiplier
                        r_state <= (r_op == OP_DZ) ? S_DIST :
                                   (r_op == OP_ZF) ? S_SAT  :
                                   (r_op == OP_MZ) ? S_FIN  : S_LOAD;
                        case (r_op)
                            OP_DX: begin
                                r_dsum <= w_prod[17:0];
                                r_op   <= OP_DY;
                            end
                            OP_DY: begin
                                r_dsum <= r_dsum + w_prod[17:0];
                                r_op   <= OP_DZ;
                            end
                            OP_DZ: begin
                                r_third <= ({1'b0, r_dsum} + w_prod[18:0]) >
                                           sco_pkg::ONE_BLOCK_SQ;
                            end
                            OP_SZ2: begin
                                r_z2 <= w_sh14[14:0];
                                r_op <= OP_ST1;
                            end
                            OP_ST1: begin
                                r_t  <= sco_pkg::SIN_C3 - w_sh14[14:0];
                                r_op <= OP_ST2;
                            end
                            OP_ST2: begin
                                r_t  <= sco_pkg::SIN_C1 - w_sh14[14:0];
                                r_op <= OP_SP;
                            end
                            OP_SP: begin
                                case (r_idx)
                                    2'd0:    r_sy  <= w_sin;
                                    2'd1:    r_cyw <= w_sin;
                                    2'd2:    r_sp  <= w_sin;
                                    default: r_cp  <= w_sin;
                                endcase
                                if (r_idx == 2'd3) begin
                                    r_op <= OP_FWX;
                                end else begin
                                    r_idx <= r_idx + 2'd1;
                                    r_op  <= OP_SZ2;
                                end
                            end
                            OP_FWX: begin
                                r_fwx <= -w_r14[15:0];
                                r_op  <= OP_FWZ;
                            end
                            OP_FWZ: begin
                                r_fwz <= w_r14[15:0];
                                r_op  <= OP_XR;
                            end
                            OP_XR: begin
                                r_tx <= 34'(r_px) + w_r14[33:0];
                                r_op <= OP_XF;
                            end
                            OP_XF: begin
                                r_tx <= r_tx + w_r14[33:0];
                                r_op <= OP_YF;
                            end
                            OP_YF: begin
                                r_ty <= 34'(r_py) + 34'(r_ofs_up) + w_r14[33:0];
                                r_op <= OP_ZR;
                            end
                            OP_ZR: begin
                                r_tz <= 34'(r_pz) + w_r14[33:0];
                                r_op <= OP_ZF;
                            end
                            OP_ZF: begin
                                r_tz <= r_tz + w_r14[33:0];
                            end
                            OP_MX: begin
                                r_tx <= 34'(r_last_x) + w_r8[33:0];
                                r_op <= OP_MY;
                            end
                            OP_MY: begin
                                r_ty <= 34'(r_last_y) + w_r8[33:0];
                                r_op <= OP_MZ;
                            end
                            default: begin
                                r_tz <= 34'(r_last_z) + w_r8[33:0];
                            end
                        endcase
                    end
                end

                // first-person frames in third-person-only mode pass through
                S_DIST: begin
                    if (r_third_only && !r_third) begin
                        r_has_last  <= 1'b0;
                        r_res_apply <= 1'b0;
                        r_res_third <= 1'b0;
                        r_res_x     <= '0;
                        r_res_y     <= '0;
                        r_res_z     <= '0;
                        r_state     <= S_DONE;
                    end else if (!r_follow) begin
                        r_tx    <= 34'(r_px) + 34'(r_ofs_right);
                        r_ty    <= 34'(r_py) + 34'(r_ofs_up);
                        r_tz    <= 34'(r_pz) + 34'(r_ofs_fwd);
                        r_state <= S_SAT;
                    end else begin
                        r_idx   <= 2'd0;
                        r_op    <= OP_SZ2;
                        r_state <= S_LOAD;
                    end
                end

                S_SAT: begin
                    r_tx    <= sat32(r_tx);
                    r_ty    <= sat32(r_ty);
                    r_tz    <= sat32(r_tz);
                    r_state <= S_SMOOTH;
                end

                S_SMOOTH: begin
                    if (r_has_last) begin
                        r_op    <= OP_MX;
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_FIN;
                    end
                end

                S_FIN: begin
                    r_last_x    <= r_tx[31:0];
                    r_last_y    <= r_ty[31:0];
                    r_last_z    <= r_tz[31:0];
                    r_has_last  <= 1'b1;
                    r_res_apply <= 1'b1;
                    r_res_third <= r_third;
                    r_res_x     <= r_tx[31:0];
                    r_res_y     <= r_ty[31:0];
                    r_res_z     <= r_tz[31:0];
                    r_state     <= S_DONE;
                end

                // hand over to the output register once it is free
                S_DONE: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {r_res_z, r_res_y, r_res_x};
                        r_out_user  <= {r_res_third, r_res_apply};
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_m_tuser   = r_out_user;
    assign o_cfg_ready = 1'b1;

    // ---- checks
    a_one_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second frame accepted while one is in work");

    a_mul_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_cnt <= LAST_BIT))
        else $error("multiplier ran past its last bit");

    a_history_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_has_last && r_state == S_DONE))
        else $error("history not kept after a placed camera");

    a_sine_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && r_op == OP_FWX) |->
            (r_sy <= 16'sd16384 && r_sy >= -16'sd16384 &&
             r_cp <= 16'sd16384 && r_cp >= -16'sd16384))
        else $error("sine value outside unit range");

    a_done_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res_apply) |-> r_has_last)
        else $error("applied camera without history");

endmodule
